/* rtl/core/tps_pkg.sv */
`default_nettype none
package tps_pkg;

  localparam int SEQ_LEN   = 16;
  localparam int MAX_CHAIN = 64;

  localparam int IDX_W   = $clog2(SEQ_LEN);
  localparam int STEP_W  = 4;
  localparam int CI_W    = (IDX_W + 1 > STEP_W) ? IDX_W + 1 : STEP_W;
  localparam int CHAIN_W = $clog2(MAX_CHAIN + 1);
  localparam int TICK_W  = 24;
  localparam int TPU_W   = 16;

  localparam logic [TPU_W-1:0] TPU_RESET = 16'd1000;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_PLAY      = 3'd1,
    OP_PLAY_PERM = 3'd2,
    OP_OFF       = 3'd3,
    OP_TICK      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_STOP   = 2'd0,
    K_TONE   = 2'd1,
    K_PAUSE  = 2'd2,
    K_REPEAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] entry_index;
    logic [1:0] entry_kind;
    logic [7:0] entry_time;
    logic [2:0] entry_count;
    logic [3:0] entry_step;
  } in_item_t;

  typedef struct packed {
    logic buzzer_on;
    logic playing;
    logic alarm_active;
    logic runaway;
  } result_t;

  typedef struct packed {
    logic [3:0] step;
    logic [2:0] count;
    logic [7:0] time_units;
    logic [1:0] kind;
  } entry_t;

  typedef struct packed {
    logic wr_entry;
    logic halt;
    logic load_counts;
    logic set_alarm;
    logic clr_alarm;
    logic set_rewritten;
    logic clr_rewritten;
    logic tick_dec;
    logic walk_step;
    logic set_runaway;
    logic clr_runaway;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic alarm;
    logic rewritten;
    logic rem_le1;
    logic walk_end;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/tps_ctrl.sv */
`default_nettype none
module tps_ctrl
  import tps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] opcode_i,
  input  wire dp_status_t sts_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  ctl_state_e state_q, state_d;
  logic [CHAIN_W-1:0] chain_q, chain_d;
  logic perm_ignored;
  logic chain_full;

  assign perm_ignored = sts_i.alarm && !sts_i.rewritten;
  assign chain_full   = (chain_q == CHAIN_W'(MAX_CHAIN));

  // next state
  always_comb begin
    state_d = state_q;
    chain_d = chain_q;
    case (state_q)
      ST_IDLE: begin
        chain_d = '0;
        if (start_i) begin
          state_d = ST_DONE;
          case (op_e'(opcode_i))
            OP_PLAY:      state_d = ST_WALK;
            OP_PLAY_PERM: if (!perm_ignored) state_d = ST_WALK;
            OP_TICK:      if (sts_i.running && sts_i.rem_le1) state_d = ST_WALK;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        if (chain_full || sts_i.walk_end) begin
          state_d = ST_DONE;
        end else begin
          chain_d = chain_q + CHAIN_W'(1);
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.clr_runaway = 1'b1;
          case (op_e'(opcode_i))
            OP_WRITE: cmd_o.wr_entry = 1'b1;
            OP_PLAY: begin
              cmd_o.halt        = 1'b1;
              cmd_o.load_counts = 1'b1;
            end
            OP_PLAY_PERM: begin
              if (!perm_ignored) begin
                cmd_o.set_alarm     = 1'b1;
                cmd_o.clr_rewritten = 1'b1;
                cmd_o.halt          = 1'b1;
                cmd_o.load_counts   = 1'b1;
              end
            end
            OP_OFF: begin
              cmd_o.halt          = 1'b1;
              cmd_o.clr_alarm     = 1'b1;
              cmd_o.set_rewritten = 1'b1;
            end
            OP_TICK: cmd_o.tick_dec = sts_i.running;
            default: cmd_o.clr_runaway = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        if (chain_full) begin
          cmd_o.halt        = 1'b1;
          cmd_o.set_runaway = 1'b1;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_DONE: done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= '0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tps_datapath.sv */
`default_nettype none
module tps_datapath
  import tps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire in_item_t         in_item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [TPU_W-1:0] cfg_wdata_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_status_t            sts_o,
  output result_t               result_o
);

  entry_t            entry_q [SEQ_LEN];
  entry_t            entry_d [SEQ_LEN];
  logic [2:0]        count_q [SEQ_LEN];
  logic [2:0]        count_d [SEQ_LEN];
  logic [CI_W-1:0]   ci_q, ci_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic              running_q, running_d;
  logic              alarm_q, alarm_d;
  logic              buzzer_q, buzzer_d;
  logic              rewritten_q, rewritten_d;
  logic              runaway_q, runaway_d;
  logic [TPU_W-1:0]  tpu_q;

  logic              in_range;
  logic              is_last;
  logic [IDX_W-1:0]  cur_idx;
  entry_t            cur;
  logic [2:0]        cur_cnt;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_ok;
  logic              walk_end;

  assign in_range = (ci_q < CI_W'(SEQ_LEN));
  assign is_last  = (ci_q == CI_W'(SEQ_LEN - 1));
  assign cur_idx  = ci_q[IDX_W-1:0];
  assign cur      = in_range ? entry_q[cur_idx] : '0;
  assign cur_cnt  = in_range ? count_q[cur_idx] : '0;
  assign wr_idx   = IDX_W'(in_item_i.entry_index);
  assign wr_ok    = (32'(in_item_i.entry_index) < SEQ_LEN);

  always_comb begin
    entry_d     = entry_q;
    count_d     = count_q;
    ci_d        = ci_q;
    rem_d       = rem_q;
    running_d   = running_q;
    alarm_d     = alarm_q;
    buzzer_d    = buzzer_q;
    rewritten_d = rewritten_q;
    runaway_d   = runaway_q;
    walk_end    = 1'b0;

    if (cmd_i.clr_runaway) runaway_d = 1'b0;
    if (cmd_i.set_runaway) runaway_d = 1'b1;
    if (cmd_i.set_alarm) alarm_d = 1'b1;
    if (cmd_i.clr_alarm) alarm_d = 1'b0;
    if (cmd_i.set_rewritten) rewritten_d = 1'b1;
    if (cmd_i.clr_rewritten) rewritten_d = 1'b0;

    if (cmd_i.halt) begin
      running_d = 1'b0;
      buzzer_d  = 1'b0;
      rem_d     = '0;
      ci_d      = '0;
    end
    if (cmd_i.load_counts) begin
      for (int i = 0; i < SEQ_LEN; i++) count_d[i] = entry_q[i].count;
    end

    if (cmd_i.wr_entry && wr_ok) begin
      entry_d[wr_idx].kind       = in_item_i.entry_kind;
      entry_d[wr_idx].time_units = in_item_i.entry_time;
      entry_d[wr_idx].count      = in_item_i.entry_count;
      entry_d[wr_idx].step       = in_item_i.entry_step;
      rewritten_d = 1'b1;
    end

    if (cmd_i.tick_dec && (rem_q != '0)) rem_d = rem_q - TICK_W'(1);

    if (cmd_i.walk_step) begin
      if (!in_range) begin
        // jump past the end: stop without restart
        running_d = 1'b0;
        buzzer_d  = 1'b0;
        rem_d     = '0;
        ci_d      = '0;
        walk_end  = 1'b1;
      end else if (is_last || kind_e'(cur.kind) == K_STOP) begin
        running_d = 1'b0;
        buzzer_d  = 1'b0;
        rem_d     = '0;
        ci_d      = '0;
        if (alarm_q) begin
          // permanent mode wraps to entry zero with fresh counts
          for (int i = 0; i < SEQ_LEN; i++) count_d[i] = entry_q[i].count;
        end else begin
          walk_end = 1'b1;
        end
      end else begin
        case (kind_e'(cur.kind))
          K_TONE, K_PAUSE: begin
            buzzer_d  = (kind_e'(cur.kind) == K_TONE);
            rem_d     = TICK_W'(cur.time_units) * TICK_W'(tpu_q);
            running_d = 1'b1;
            ci_d      = ci_q + CI_W'(1);
            walk_end  = 1'b1;
          end
          default: begin
            if (cur_cnt == 3'd0) begin
              ci_d = CI_W'(cur.step);
            end else if (cur_cnt == 3'd1) begin
              ci_d = ci_q + CI_W'(1);
            end else begin
              count_d[cur_idx] = cur_cnt - 3'd1;
              ci_d             = CI_W'(cur.step);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEQ_LEN; i++) begin
        entry_q[i] <= '0;
        count_q[i] <= '0;
      end
      ci_q        <= '0;
      rem_q       <= '0;
      running_q   <= 1'b0;
      alarm_q     <= 1'b0;
      buzzer_q    <= 1'b0;
      rewritten_q <= 1'b1;
      runaway_q   <= 1'b0;
      tpu_q       <= TPU_RESET;
    end else begin
      entry_q     <= entry_d;
      count_q     <= count_d;
      ci_q        <= ci_d;
      rem_q       <= rem_d;
      running_q   <= running_d;
      alarm_q     <= alarm_d;
      buzzer_q    <= buzzer_d;
      rewritten_q <= rewritten_d;
      runaway_q   <= runaway_d;
      if (cfg_we_i) tpu_q <= cfg_wdata_i;
    end
  end

  assign sts_o.running   = running_q;
  assign sts_o.alarm     = alarm_q;
  assign sts_o.rewritten = rewritten_q;
  assign sts_o.rem_le1   = (rem_q <= TICK_W'(1));
  assign sts_o.walk_end  = walk_end;

  assign result_o.buzzer_on    = buzzer_q;
  assign result_o.playing      = running_q;
  assign result_o.alarm_active = alarm_q;
  assign result_o.runaway      = runaway_q;

endmodule
`default_nettype wire

/* rtl/core/tone_pattern_sequencer_unit.sv */
`default_nettype none
// buzzer pattern sequencer: runs a 16-entry program of tone, pause, repeat and stop
// commands, counted down by tick items
// command channel: in_item_i is taken at a clock edge with start high and busy low;
//   the opcode selects entry write, play, permanent play, off or tick
// result channel: done_o is high for exactly one cycle with result_o (buzzer level,
//   playing, permanent mode, runaway flag); the receiver cannot hold it off
// config channel: cfg_wdata_i sets ticks per time unit on a cfg_valid_i transfer;
//   cfg_ready_o is always high, writes belong in idle time
// write, off, a tick that does not end a command and an ignored permanent play reach
//   done in the cycle after accept; play, permanent play and a tick that ends a
//   command walk the program one entry a cycle until the walk ends or MAX_CHAIN stops it
// the block takes one item at a time; busy stays high until the result cycle is over,
//   so the next item goes in the cycle after done_o
// the entry walk in the datapath steps one program entry per cycle
// reset: all entries read as stop, loop counts cleared, nothing playing, ticks per
//   unit 1000
module tone_pattern_sequencer_unit
  import tps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item_i,
  output logic                  done_o,
  output result_t               result_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [TPU_W-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // ticks per unit is only sampled by the walk, so a write is always safe to take
  assign cfg_ready_o = 1'b1;

  // controller: decodes the opcode on accept, paces the walk, limits the chain
  tps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (in_item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // datapath: program store, loop counts, tick counter and sequencer flags
  tps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

  // the buzzer only sounds while a sequence is timing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.buzzer_on |-> result_o.playing)
    else $error("buzzer on while not playing");

  // a runaway stop leaves the sequence halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.runaway) |-> (!result_o.playing && !result_o.buzzer_on))
    else $error("runaway result with sequence still running");

  // an accepted command always makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item without busy");

  // the result strobe lasts one cycle and is followed by idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

endmodule
`default_nettype wire
